FILE: hdl/pdec_pkg.sv
// pdec_pkg: shared constants, command type and hex helpers for the percent decoder
// used by every module of url_percent_decoder_core; depends on nothing
`default_nettype none

package pdec_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;
    localparam logic [7:0] LOWER_LO   = 8'h61;
    localparam logic [7:0] LOWER_HI   = 8'h66;
    localparam logic [7:0] UPPER_LO   = 8'h41;
    localparam logic [7:0] UPPER_HI   = 8'h46;
    localparam logic [3:0] LETTER_OFS = 4'd9;

    // escape phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_DIG  = 2'd2;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int MAX_OUT = 3;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // one accepted request turned into up to three output bytes
    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        logic [MAX_OUT-1:0][7:0]  data;
        logic                     last;
    } cmd_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= DIGIT_LO) && (c <= DIGIT_HI);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c)
            || ((c >= LOWER_LO) && (c <= LOWER_HI))
            || ((c >= UPPER_LO) && (c <= UPPER_HI));
    endfunction

    // valid only when is_hex holds; letters have low nibble 1..6
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return is_digit(c) ? c[3:0] : c[3:0] + LETTER_OFS;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pdec_if.sv
// pdec_in_if / pdec_out_if: valid-ready channels for encoded and decoded bytes
// no dependencies
`default_nettype none

interface pdec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pdec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/pdec_front.sv
// pdec_front: accepts encoded bytes, tracks the escape phase, builds output commands
// depends on pdec_pkg and pdec_in_if
`default_nettype none

module pdec_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pdec_in_if.sink          in_ch,
    output pdec_pkg::cmd_t   cmd,
    output logic             cmd_valid,
    input  wire logic        cmd_ready
);
    import pdec_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;

    function automatic cmd_t push(input cmd_t c, input logic [7:0] v);
        cmd_t r;
        r = c;
        case (c.cnt)
            2'd0:    r.data[0] = v;
            2'd1:    r.data[1] = v;
            default: r.data[2] = v;
        endcase
        r.cnt = c.cnt + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_ch.in_byte))
                begin
                    held_next  = in_ch.in_byte;
                    phase_next = PH_DIG;
                end
                else
                begin
                    cmd = push(cmd, PCT_CHAR);
                    if (in_ch.in_byte == PCT_CHAR)
                        phase_next = PH_PCT;
                    else
                    begin
                        cmd        = push(cmd, in_ch.in_byte);
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_DIG:
            begin
                if (is_hex(in_ch.in_byte) && is_hex(held_reg))
                begin
                    cmd        = push(cmd, {hex_val(held_reg), hex_val(in_ch.in_byte)});
                    phase_next = PH_IDLE;
                end
                else
                begin
                    cmd = push(cmd, PCT_CHAR);
                    cmd = push(cmd, held_reg);
                    if (in_ch.in_byte == PCT_CHAR)
                        phase_next = PH_PCT;
                    else
                    begin
                        cmd        = push(cmd, in_ch.in_byte);
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                if (in_ch.in_byte == PCT_CHAR)
                    phase_next = PH_PCT;
                else
                begin
                    cmd        = push(cmd, in_ch.in_byte);
                    phase_next = PH_IDLE;
                end
            end
        endcase

        // end of string: flush whatever is held
        if (in_ch.in_last)
        begin
            if (phase_next == PH_PCT)
                cmd = push(cmd, PCT_CHAR);
            else if (phase_next == PH_DIG)
            begin
                cmd = push(cmd, PCT_CHAR);
                cmd = push(cmd, held_next);
            end
            phase_next = PH_IDLE;
            cmd.last   = 1'b1;
        end
    end

    assign in_ch.ready = cmd_ready;
    assign accept      = in_ch.valid && cmd_ready;
    assign cmd_valid   = in_ch.valid && (cmd.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pdec_queue.sv
// pdec_queue: short command queue between front and back
// depends on pdec_pkg
`default_nettype none

module pdec_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pdec_pkg::cmd_t wr_cmd,
    input  wire logic        wr_valid,
    output logic             wr_ready,
    output pdec_pkg::cmd_t   rd_cmd,
    output logic             rd_valid,
    input  wire logic        rd_ready
);
    import pdec_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pdec_back.sv
// pdec_back: unrolls each queued command into output bytes behind an output register
// depends on pdec_pkg and pdec_out_if
`default_nettype none

module pdec_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pdec_pkg::cmd_t cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_pop,
    pdec_out_if.source       out_ch
);
    import pdec_pkg::*;

    logic [CNT_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg, byte_sel;
    logic             out_last_reg;
    logic             load, at_end;

    assign load    = cmd_valid && (!out_valid_reg || out_ch.ready);
    assign at_end  = (idx_reg == cmd.cnt - 1'b1);
    assign cmd_pop = load && at_end;

    always_comb
    begin
        case (idx_reg)
            2'd0:    byte_sel = cmd.data[0];
            2'd1:    byte_sel = cmd.data[1];
            default: byte_sel = cmd.data[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_end ? '0 : idx_reg + 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= cmd.last && at_end;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

endmodule

`default_nettype wire

FILE: hdl/url_percent_decoder_core.sv
// url_percent_decoder_core: top level of the streaming url percent decoder
// depends on pdec_pkg, pdec_if, pdec_front, pdec_queue, pdec_back
`default_nettype none

// Streaming percent decoder. Each input request carries one encoded byte and a
// last-of-string flag; "%XY" with two hex digits (either case) turns into one
// byte, everything else passes through, and a broken escape is emitted
// literally before the breaking byte is judged afresh. The front stage takes one
// request per cycle whenever the four-entry command queue has room, with no
// bubbles between requests; each request becomes a command of zero to three
// output bytes. The back stage drains the queue at one output byte per cycle
// while the output channel is ready, through a registered output; sustained
// runs of broken escapes (two or three bytes out per request) or a stalled
// output channel fill the queue and throttle the input. A decoded byte reaches
// the output through a queue entry and then the output register. The final
// byte of every string carries out_last, and a last request always produces
// at least one byte.

module url_percent_decoder_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pdec_in_if.sink     in_ch,
    pdec_out_if.source  out_ch
);
    import pdec_pkg::*;

    // front to queue
    cmd_t f_cmd;
    logic f_valid;
    logic f_ready;

    // queue to back
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    // classify each byte and track the pending escape
    pdec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (f_cmd),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready)
    );

    // decouples input acceptance from multi-byte output expansion
    pdec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (f_cmd),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_cmd   (q_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_pop)
    );

    // one decoded byte per cycle onto the output channel while it is ready
    pdec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for url_percent_decoder_core, random and directed encoded strings
// depends on pdec_pkg, pdec_in_if / pdec_out_if and the decoder rtl
`timescale 1ns / 100ps

module tb;

    import pdec_pkg::*;

    // one decoded byte as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    // tracks escape state and holds the decoded bytes still owed by the block
    class decode_scoreboard;
        dec_byte_t  owed_q[$];
        dec_byte_t  step_q[$];
        logic [1:0] esc_phase;
        logic [7:0] held_digit;
        int         mismatches;
        int         checked;

        function new();
            esc_phase  = PH_IDLE;
            held_digit = 8'h00;
            mismatches = 0;
            checked    = 0;
        endfunction

        // hex weight of a character, -1 when it is not a hex digit
        static function int nibble_of(logic [7:0] c);
            if (c >= DIGIT_LO && c <= DIGIT_HI)
            begin
                return int'(c - DIGIT_LO);
            end
            if (c >= LOWER_LO && c <= LOWER_HI)
            begin
                return int'(c - LOWER_LO) + 10;
            end
            if (c >= UPPER_LO && c <= UPPER_HI)
            begin
                return int'(c - UPPER_LO) + 10;
            end
            return -1;
        endfunction

        function void owe(logic [7:0] b);
            step_q.push_back('{data: b, last: 1'b0});
        endfunction

        // byte seen with nothing pending
        function void judge_fresh(logic [7:0] b);
            if (b == PCT_CHAR)
            begin
                esc_phase = PH_PCT;
            end
            else
            begin
                esc_phase = PH_IDLE;
                owe(b);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // an encoded request was accepted: work out what it must produce
        function void take_encoded(logic [7:0] b, logic l);
            int hv;
            int hd;
            step_q.delete();
            hv = nibble_of(b);
            case (esc_phase)
                PH_PCT:
                begin
                    if (hv >= 0)
                    begin
                        held_digit = b;
                        esc_phase  = PH_DIG;
                    end
                    else
                    begin
                        owe(PCT_CHAR);
                        judge_fresh(b);
                    end
                end
                PH_DIG:
                begin
                    hd = nibble_of(held_digit);
                    if (hv >= 0 && hd >= 0)
                    begin
                        owe(8'(hd * 16 + hv));
                        esc_phase = PH_IDLE;
                    end
                    else
                    begin
                        owe(PCT_CHAR);
                        owe(held_digit);
                        judge_fresh(b);
                    end
                end
                default:
                begin
                    judge_fresh(b);
                end
            endcase
            if (l)
            begin
                if (esc_phase == PH_PCT)
                begin
                    owe(PCT_CHAR);
                end
                else if (esc_phase == PH_DIG)
                begin
                    owe(PCT_CHAR);
                    owe(held_digit);
                end
                esc_phase = PH_IDLE;
                if (step_q.size() > 0)
                begin
                    step_q[step_q.size() - 1].last = 1'b1;
                end
            end
            foreach (step_q[i])
            begin
                owed_q.push_back(step_q[i]);
            end
        endfunction

        // a decoded byte was accepted: compare with the oldest one owed
        function void check_decoded(logic [7:0] b, logic l);
            dec_byte_t want;
            if (owed_q.size() == 0)
            begin
                $error("decoded byte %h (last %b) with none owed", b, l);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (b !== want.data)
            begin
                $error("out_byte: expected %h, actual %h", want.data, b);
                mismatches++;
            end
            if (l !== want.last)
            begin
                $error("out_last: expected %b, actual %b", want.last, l);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pdec_in_if  in_ch ();
    pdec_out_if out_ch ();

    url_percent_decoder_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    decode_scoreboard sb;

    // no idling on either side once this is set
    logic       calm;
    int         items_sent;
    int         strings_sent;
    logic [7:0] str_q[$];

    always #5 clk = ~clk;

    // request monitor: every accepted encoded byte feeds the prediction
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            sb.take_encoded(in_ch.in_byte, in_ch.in_last);
        end
    end

    // result monitor: every accepted decoded byte is checked in order
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            sb.check_decoded(out_ch.out_byte, out_ch.out_last);
        end
    end

    // receiver: ready comes in runs broken by random stall bursts
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            if (calm)
            begin
                @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 20)) @(posedge clk);
                if (!calm)
                begin
                    out_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                end
            end
        end
    end

    // hang guard; worst legal run is far shorter than this
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // present one encoded byte and hold it until the request is taken
    task automatic send_encoded(input logic [7:0] b, input logic l);
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= l;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        // sender gap after the request, sometimes
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // whole string, last flag on the final byte
    task automatic send_string(input logic [7:0] s[$]);
        foreach (s[i])
        begin
            send_encoded(s[i], i == s.size() - 1);
        end
        strings_sent++;
    endtask

    function automatic logic [7:0] pick_hex();
        case ($urandom_range(0, 2))
            0:       return DIGIT_LO + 8'($urandom_range(0, 9));
            1:       return LOWER_LO + 8'($urandom_range(0, 5));
            default: return UPPER_LO + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // characters just outside the hex ranges, or a random byte
    function automatic logic [7:0] pick_non_hex();
        logic [7:0] edges [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0)
        begin
            return edges[3'($urandom_range(0, 5))];
        end
        c = 8'($urandom_range(0, 255));
        return (decode_scoreboard::nibble_of(c) >= 0) ? 8'h2F : c;
    endfunction

    // append one piece of an encoded string: mostly good escapes and plain text
    function automatic void add_piece();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            str_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 75)
        begin
            str_q.push_back(PCT_CHAR);
            str_q.push_back(pick_hex());
            str_q.push_back(pick_hex());
        end
        else if (r < 85)
        begin
            // broken right after the percent sign
            str_q.push_back(PCT_CHAR);
            str_q.push_back(pick_non_hex());
        end
        else if (r < 93)
        begin
            // broken after one digit, sometimes by a new percent sign
            str_q.push_back(PCT_CHAR);
            str_q.push_back(pick_hex());
            str_q.push_back(($urandom_range(0, 2) == 0) ? PCT_CHAR : pick_non_hex());
        end
        else
        begin
            str_q.push_back(PCT_CHAR);
        end
    endfunction

    initial
    begin
        sb            = new();
        calm          = 1'b0;
        items_sent    = 0;
        strings_sent  = 0;
        rst_n         = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes and a percent broken by 0xff
        send_string({8'h00, PCT_CHAR, 8'hFF});
        // escape completing on the last byte, lower-case digit
        send_string({PCT_CHAR, 8'h34, 8'h61});
        // percent breaks a percent, then a digit is broken by a non-hex letter
        send_string({PCT_CHAR, PCT_CHAR, 8'h34, 8'h47});
        // string ends with one digit held
        send_string({PCT_CHAR, 8'h46});
        // string ends with only a percent sign held
        send_string({PCT_CHAR});
        // percent breaks a held digit and starts a good escape
        send_string({PCT_CHAR, 8'h34, PCT_CHAR, 8'h34, 8'h31});
        // decoded extremes, mixed case
        send_string({PCT_CHAR, 8'h46, 8'h66, PCT_CHAR, 8'h30, 8'h30});

        // random strings of a few pieces each
        while (items_sent < 310)
        begin
            str_q.delete();
            repeat ($urandom_range(1, 6)) add_piece();
            if (items_sent >= 270)
            begin
                calm = 1'b1;
            end
            send_string(str_q);
            if (strings_sent == 15)
            begin
                // hold off until the block has caught up completely
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        // then wait on to catch any stray bytes
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d decoded bytes never arrived", sb.pending());
            sb.mismatches++;
        end

        $display("run: %0d encoded bytes in %0d strings, %0d decoded bytes checked",
                 items_sent, strings_sent, sb.checked);
        if (sb.mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
